FILE: rtl/fqsp_pkg.sv
// Shared types, constants and the hex digit decoder of the FASTQ record splitter.
package fqsp_pkg;

    localparam int unsigned WORD_BITS_DEF       = 64;
    localparam int unsigned LINE_COUNT_BITS_DEF = 16;
    localparam int unsigned OUT_WORD_BITS       = 64;
    localparam int unsigned ID_LEN_BITS         = 12;

    localparam logic [ID_LEN_BITS-1:0] ID_LEN_MAX = '1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_ID     = 3'd0,
        PH_HDR    = 3'd1,
        PH_SEQ    = 3'd2,
        PH_SPACER = 3'd3,
        PH_QUAL   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_CLEAN = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_fqsp_in;

    typedef struct packed {
        logic [OUT_WORD_BITS-1:0] id_word;
        logic                     id_word_valid;
        logic                     id_last;
        logic [ID_LEN_BITS-1:0]   id_length;
        logic                     record_done;
        logic [1:0]               stream_status;
    } t_fqsp_out;

    // Result of one byte step, handed from the parser to the output register.
    typedef struct packed {
        logic      valid;
        t_fqsp_out rsp;
    } t_step_res;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h57;
            return {1'b1, v[3:0]};
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            v = b - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

FILE: rtl/fastq_record_splitter_id_packer_core.sv
// A result appears on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the phase and id registers update from each byte alone.
// Input stalls only while a result sits in the output register and the sink stalls.
// Reset (synchronous, active low) returns to the id phase with all counters and the
// id accumulator cleared, and empties the output register.
module fastq_record_splitter_id_packer_core #(
    parameter int unsigned WORD_BITS       = fqsp_pkg::WORD_BITS_DEF,
    parameter int unsigned LINE_COUNT_BITS = fqsp_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fqsp_pkg::t_fqsp_in   i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fqsp_pkg::t_fqsp_out  o_out_rsp
);

    logic                room;
    logic                step;
    fqsp_pkg::t_step_res res;

    assign o_in_stall = !room;
    assign step       = i_in_valid && room;

    fqsp_parser #(
        .WORD_BITS       (WORD_BITS),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (i_in_req),
        .o_res   (res)
    );

    fqsp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_step  (step),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_rsp   (o_out_rsp)
    );

endmodule

FILE: rtl/fqsp_parser.sv
// Record phase tracker and id nibble packer: one stream byte per accepted request.
module fqsp_parser #(
    parameter int unsigned WORD_BITS       = fqsp_pkg::WORD_BITS_DEF,
    parameter int unsigned LINE_COUNT_BITS = fqsp_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  fqsp_pkg::t_fqsp_in   i_req,
    output fqsp_pkg::t_step_res  o_res
);

    localparam int unsigned NIBBLES = WORD_BITS / 4;
    localparam int unsigned NIB_W   = (NIBBLES > 1) ? $clog2(NIBBLES) : 1;
    localparam logic [NIB_W-1:0]           NIB_LAST = NIB_W'(NIBBLES - 1);
    localparam logic [LINE_COUNT_BITS-1:0] LC_MAX   = '1;
    localparam logic [LINE_COUNT_BITS-1:0] LC_ONE   = LINE_COUNT_BITS'(1);

    fqsp_pkg::t_phase                  r_phase, n_phase;
    logic [WORD_BITS-1:0]              r_accum, n_accum;
    logic [NIB_W-1:0]                  r_nib,   n_nib;
    logic [fqsp_pkg::ID_LEN_BITS-1:0]  r_idc,   n_idc;
    logic [LINE_COUNT_BITS-1:0]        r_lc,    n_lc;

    logic [4:0]                        hex;
    logic [WORD_BITS-1:0]              word;
    logic                              wv, il, done;
    logic [fqsp_pkg::ID_LEN_BITS-1:0]  len;
    fqsp_pkg::t_status                 status;
    logic [LINE_COUNT_BITS-1:0]        lc_dec;
    logic [fqsp_pkg::OUT_WORD_BITS-1:0] word_ext;

    assign hex = fqsp_pkg::hex_decode(i_req.in_byte);

    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_nib   = r_nib;
        n_idc   = r_idc;
        n_lc    = r_lc;
        word    = '0;
        wv      = 1'b0;
        il      = 1'b0;
        len     = '0;
        done    = 1'b0;
        status  = fqsp_pkg::ST_RUN;
        lc_dec  = (r_lc != '0) ? r_lc - LC_ONE : r_lc;

        unique case (r_phase)
            fqsp_pkg::PH_ID: begin
                if (i_req.in_byte == fqsp_pkg::CH_LF && r_idc == '0 && r_nib == '0) begin
                    // skip blank line ahead of the header
                end else if (i_req.in_byte <= fqsp_pkg::CH_SPACE) begin
                    word    = r_accum;
                    wv      = (r_nib != '0);
                    il      = 1'b1;
                    len     = r_idc;
                    n_accum = '0;
                    n_nib   = '0;
                    n_idc   = '0;
                    n_lc    = '0;
                    n_phase = (i_req.in_byte == fqsp_pkg::CH_LF) ? fqsp_pkg::PH_SEQ
                                                                  : fqsp_pkg::PH_HDR;
                end else begin
                    if (r_idc < fqsp_pkg::ID_LEN_MAX) begin
                        n_idc = r_idc + 1'b1;
                    end
                    if (hex[4]) begin
                        // slot at r_nib is still clear, so write the digit in place
                        for (int k = 0; k < NIBBLES; k++) begin
                            if (r_nib == NIB_W'(k)) begin
                                n_accum[4*k +: 4] = hex[3:0];
                            end
                        end
                        if (r_nib == NIB_LAST) begin
                            word    = n_accum;
                            wv      = 1'b1;
                            n_accum = '0;
                            n_nib   = '0;
                        end else begin
                            n_nib = r_nib + 1'b1;
                        end
                    end
                end
            end
            fqsp_pkg::PH_HDR: begin
                if (i_req.in_byte == fqsp_pkg::CH_LF) begin
                    n_phase = fqsp_pkg::PH_SEQ;
                end
            end
            fqsp_pkg::PH_SEQ: begin
                if (i_req.in_byte == fqsp_pkg::CH_PLUS) begin
                    n_phase = fqsp_pkg::PH_SPACER;
                end else if (i_req.in_byte == fqsp_pkg::CH_LF && r_lc != LC_MAX) begin
                    n_lc = r_lc + 1'b1;
                end
            end
            fqsp_pkg::PH_SPACER: begin
                if (i_req.in_byte == fqsp_pkg::CH_LF) begin
                    if (r_lc == '0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = fqsp_pkg::PH_QUAL;
                    end
                end
            end
            fqsp_pkg::PH_QUAL: begin
                if (i_req.in_byte == fqsp_pkg::CH_LF) begin
                    n_lc = lc_dec;
                    done = (lc_dec == '0);
                end
            end
            default: begin
                n_phase = fqsp_pkg::PH_ID;
            end
        endcase

        if (done) begin
            n_phase = fqsp_pkg::PH_ID;
            n_accum = '0;
            n_nib   = '0;
            n_idc   = '0;
            n_lc    = '0;
        end

        if (i_req.last_byte) begin
            if (n_phase == fqsp_pkg::PH_ID && n_idc == '0 && n_nib == '0) begin
                status = fqsp_pkg::ST_CLEAN;
            end else if (n_phase == fqsp_pkg::PH_QUAL && n_lc == LC_ONE) begin
                // accept a missing final quality newline
                done   = 1'b1;
                status = fqsp_pkg::ST_CLEAN;
            end else begin
                status = fqsp_pkg::ST_TRUNC;
                if (n_phase == fqsp_pkg::PH_ID) begin
                    word = n_accum;
                    wv   = (n_nib != '0);
                    il   = 1'b1;
                    len  = n_idc;
                end
            end
            n_phase = fqsp_pkg::PH_ID;
            n_accum = '0;
            n_nib   = '0;
            n_idc   = '0;
            n_lc    = '0;
        end

        word_ext                 = '0;
        word_ext[WORD_BITS-1:0]  = word;
        o_res.valid              = wv | il | done | i_req.last_byte;
        o_res.rsp.id_word        = wv ? word_ext : '0;
        o_res.rsp.id_word_valid  = wv;
        o_res.rsp.id_last        = il;
        o_res.rsp.id_length      = il ? len : '0;
        o_res.rsp.record_done    = done;
        o_res.rsp.stream_status  = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fqsp_pkg::PH_ID;
            r_accum <= '0;
            r_nib   <= '0;
            r_idc   <= '0;
            r_lc    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_nib   <= n_nib;
            r_idc   <= n_idc;
            r_lc    <= n_lc;
        end
    end

    a_nib_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nib <= NIB_LAST)
        else $error("nibble count beyond word");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_req.last_byte) |=>
            (r_phase == fqsp_pkg::PH_ID && r_nib == '0 && r_idc == '0 && r_lc == '0
             && r_accum == '0))
        else $error("state not cleared after final byte");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.rsp.record_done) |=>
            (r_phase == fqsp_pkg::PH_ID && r_idc == '0 && r_lc == '0))
        else $error("state not cleared after record end");

    a_id_only_in_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != fqsp_pkg::PH_ID) |-> (r_nib == '0 && r_idc == '0 && r_accum == '0))
        else $error("id accumulator busy outside id phase");

endmodule

FILE: rtl/fqsp_out_reg.sv
// Output result register that parts the upstream and downstream handshakes.
module fqsp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fqsp_pkg::t_step_res  i_res,
    input  logic                 i_step,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_stall,
    output fqsp_pkg::t_fqsp_out  o_rsp
);

    logic                r_valid;
    fqsp_pkg::t_fqsp_out r_rsp;

    assign o_room  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_step && i_res.valid;
        end
    end

    // hold the payload while a stalled request waits
    always_ff @(posedge i_clk) begin
        if (o_room) begin
            r_rsp <= i_res.rsp;
        end
    end

endmodule
